// ===== design/rtt_pkg.sv =====
package rtt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int SLOT_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = SLOT_W + 1;
  localparam logic [30:0] RESP_MAX = 31'h7FFF_FFFF;

  localparam logic [1:0] CFG_ENABLE = 2'd0;
  localparam logic [1:0] CFG_ENTRIES = 2'd1;
  localparam logic [1:0] CFG_PERIOD = 2'd2;
  localparam logic [1:0] CFG_TPS = 2'd3;

  localparam logic [2:0] ST_IGNORED = 3'd0;
  localparam logic [2:0] ST_SKIPPED = 3'd1;
  localparam logic [2:0] ST_KEPT = 3'd2;
  localparam logic [2:0] ST_RAISED = 3'd3;
  localparam logic [2:0] ST_INSERTED = 3'd4;
  localparam logic [2:0] ST_REPLACED = 3'd5;
  localparam logic [2:0] ST_DROPPED = 3'd6;
  localparam logic [2:0] ST_READ = 3'd7;

  typedef struct packed {
    logic        action;
    logic [31:0] now_tick;
    logic [31:0] arrival_tick;
    logic [31:0] client_address;
    logic        retransmitted;
    logic        ipv4_family;
    logic [5:0]  read_slot;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  slot;
    logic        entry_valid;
    logic [31:0] entry_address;
    logic [30:0] entry_response;
    logic [31:0] entry_stamp;
    logic [63:0] total_sum;
    logic [63:0] total_count;
  } out_item_t;

  typedef struct packed {
    logic        live;
    logic [31:0] addr;
    logic [30:0] resp;
    logic [31:0] stamp;
  } entry_t;

endpackage

// ===== design/response_time_topk_table.sv =====
// flow: an accepted item runs one sweep over the slot memory (aging and search, one read per
//   cycle), then decide, write, readback and result hand-off; no new item is taken until the
//   block is idle again and its last result has been taken
// reset: after rst_n the memory is cleared by a pass over every slot before the
//   first item is taken; registers return to their reset values at once
module response_time_topk_table import rtt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_DEC   = 7'b0001000,
    S_WRITE = 7'b0010000,
    S_RDBK  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // slot memory, single write port, one registered read port
  entry_t mem [TABLE_ENTRIES];
  entry_t rd_q;
  logic [SLOT_W-1:0] rd_addr, wr_addr;
  logic wr_en;
  entry_t wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  // configuration
  logic        enable_r;
  logic [6:0]  entries_r;
  logic [12:0] period_r;
  logic [9:0]  tps_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1; entries_r <= 7'd64; period_r <= 13'd60; tps_r <= 10'd100;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ENABLE:  enable_r <= cfg_data[0];
        CFG_ENTRIES: entries_r <= cfg_data[6:0];
        CFG_PERIOD:  period_r <= cfg_data[12:0];
        CFG_TPS:     tps_r <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // item context
  in_item_t    item_r;
  logic [30:0] ivl_r;
  logic [31:0] limit_r;
  logic        skip_r, ign_r;
  logic [63:0] sum_r, count_r;
  logic [CNT_W-1:0] cnt_r;           // sweep counter
  logic        scan_v_r;             // read data valid during the sweep
  logic [SLOT_W-1:0] scan_idx_r;     // slot of rd_q
  // search results
  logic        match_f_r, free_f_r, min_f_r;
  logic [SLOT_W-1:0] match_i_r, free_i_r, min_i_r;
  entry_t      match_e_r, min_e_r;
  logic [30:0] min_resp_r;
  logic [2:0]  status_r;
  logic [SLOT_W-1:0] tslot_r;
  logic        touch_r;
  entry_t      new_e_r;
  out_item_t   out_r;
  logic        out_v_r;

  logic [22:0] period_ticks;
  logic [31:0] limit_c, ivl_raw;
  logic        ignore_c;
  logic [6:0]  bound;
  entry_t      aged;
  logic        stale;

  assign period_ticks = period_r * tps_r;
  assign limit_c = in_data.now_tick - {9'd0, period_ticks};
  assign ivl_raw = in_data.now_tick - in_data.arrival_tick;
  assign ignore_c = !enable_r || in_data.arrival_tick == 32'd0 ||
                    in_data.retransmitted || !in_data.ipv4_family;
  assign bound = (entries_r > 7'(TABLE_ENTRIES)) ? 7'(TABLE_ENTRIES) : entries_r;

  // aging view of the slot just read, ignored records leave the table alone
  assign stale = !skip_r && !ign_r && rd_q.live &&
                 (((rd_q.stamp - limit_r) >> 31) != 32'd0);
  assign aged = stale ? '0 : rd_q;

  assign in_stall = (state_r != S_IDLE) || out_v_r;
  assign out_valid = out_v_r;
  assign out_data = out_r;

  function automatic logic tick_before(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  always_comb begin
    state_nxt = state_r;
    rd_addr = cnt_r[SLOT_W-1:0];
    wr_en = 1'b0;
    wr_addr = cnt_r[SLOT_W-1:0];
    wr_data = '0;
    unique case (state_r)
      S_CLEAR: begin
        wr_en = 1'b1;
        if (cnt_r == CNT_W'(TABLE_ENTRIES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: if (in_valid && !in_stall) state_nxt = S_SCAN;
      S_SCAN: begin
        // write back aged slot as it streams past
        if (scan_v_r) begin
          wr_en = stale; wr_addr = scan_idx_r; wr_data = '0;
        end
        if (scan_v_r && scan_idx_r == SLOT_W'(TABLE_ENTRIES - 1)) state_nxt = S_DEC;
      end
      S_DEC: state_nxt = S_WRITE;
      S_WRITE: begin
        wr_en = touch_r; wr_addr = tslot_r; wr_data = new_e_r;
        state_nxt = S_RDBK;
      end
      S_RDBK: begin
        rd_addr = item_r.action ? item_r.read_slot[SLOT_W-1:0] : tslot_r;
        state_nxt = S_OUT;
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; cnt_r <= '0; out_v_r <= 1'b0; scan_v_r <= 1'b0;
      sum_r <= '0; count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_v_r && !out_stall) out_v_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: cnt_r <= cnt_r + 1'b1;
        S_IDLE: begin
          cnt_r <= '0; scan_v_r <= 1'b0;
          if (in_valid && !in_stall) begin
            item_r <= in_data;
            limit_r <= limit_c;
            skip_r <= limit_c[31];
            ign_r <= !in_data.action && ignore_c;
            ivl_r <= ivl_raw[31] ? RESP_MAX : ivl_raw[30:0];
            match_f_r <= 1'b0; free_f_r <= 1'b0; min_f_r <= 1'b0;
            if (!in_data.action && !ignore_c) begin
              sum_r <= sum_r + {33'd0, (ivl_raw[31] ? RESP_MAX : ivl_raw[30:0])};
              count_r <= count_r + 64'd1;
            end
          end
        end
        S_SCAN: begin
          if (cnt_r != CNT_W'(TABLE_ENTRIES)) cnt_r <= cnt_r + 1'b1;
          scan_v_r <= (cnt_r != CNT_W'(TABLE_ENTRIES));
          scan_idx_r <= cnt_r[SLOT_W-1:0];
          if (scan_v_r) begin
            if (aged.live && aged.addr == item_r.client_address && !match_f_r) begin
              match_f_r <= 1'b1; match_i_r <= scan_idx_r; match_e_r <= aged;
            end
            if (!aged.live && !free_f_r && {1'b0, scan_idx_r} < bound[CNT_W-1:0]) begin
              free_f_r <= 1'b1; free_i_r <= scan_idx_r;
            end
            if (aged.live && (!min_f_r || aged.resp < min_resp_r)) begin
              min_f_r <= 1'b1; min_i_r <= scan_idx_r; min_e_r <= aged;
              min_resp_r <= aged.resp;
            end
          end
        end
        S_DEC: begin
          priority if (item_r.action) begin
            status_r <= ST_READ; touch_r <= 1'b0; tslot_r <= '0;
          end else if (ign_r) begin
            status_r <= ST_IGNORED; touch_r <= 1'b0; tslot_r <= '0;
          end else if (skip_r) begin
            status_r <= ST_SKIPPED; touch_r <= 1'b0; tslot_r <= '0;
          end else if (match_f_r && match_e_r.resp >= ivl_r) begin
            status_r <= ST_KEPT; touch_r <= 1'b0; tslot_r <= match_i_r;
          end else if (match_f_r) begin
            status_r <= ST_RAISED; touch_r <= 1'b1; tslot_r <= match_i_r;
            new_e_r <= '{live: 1'b1, addr: match_e_r.addr, resp: ivl_r,
                         stamp: tick_before(match_e_r.stamp, item_r.now_tick) ?
                                item_r.now_tick : match_e_r.stamp};
          end else if (free_f_r) begin
            status_r <= ST_INSERTED; touch_r <= 1'b1; tslot_r <= free_i_r;
            new_e_r <= '{live: 1'b1, addr: item_r.client_address, resp: ivl_r,
                         stamp: item_r.now_tick};
          end else if (min_f_r && ivl_r > min_e_r.resp) begin
            status_r <= ST_REPLACED; touch_r <= 1'b1; tslot_r <= min_i_r;
            new_e_r <= '{live: 1'b1, addr: item_r.client_address, resp: ivl_r,
                         stamp: tick_before(min_e_r.stamp, item_r.now_tick) ?
                                item_r.now_tick : min_e_r.stamp};
          end else begin
            status_r <= ST_DROPPED; touch_r <= 1'b0; tslot_r <= '0;
          end
        end
        S_OUT: begin
          out_v_r <= 1'b1;
          out_r.status <= status_r;
          out_r.total_sum <= sum_r;
          out_r.total_count <= count_r;
          if (status_r == ST_READ) begin
            out_r.slot <= item_r.read_slot;
            out_r.entry_valid <= rd_q.live;
            out_r.entry_address <= rd_q.addr;
            out_r.entry_response <= rd_q.resp;
            out_r.entry_stamp <= rd_q.stamp;
          end else if (status_r == ST_KEPT || status_r == ST_RAISED ||
                       status_r == ST_INSERTED || status_r == ST_REPLACED) begin
            out_r.slot <= 6'(tslot_r);
            out_r.entry_valid <= rd_q.live;
            out_r.entry_address <= rd_q.addr;
            out_r.entry_response <= rd_q.resp;
            out_r.entry_stamp <= rd_q.stamp;
          end else begin
            out_r.slot <= '0; out_r.entry_valid <= 1'b0; out_r.entry_address <= '0;
            out_r.entry_response <= '0; out_r.entry_stamp <= '0;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("result dropped");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && !in_stall && !in_data.action && !ignore_c)
    |=> (count_r == $past(count_r) + 64'd1)) else $error("count not advanced");
`endif

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  import rtt_pkg::*;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  // dut ports
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_ENABLE;
  logic [31:0] cfg_data = '0;

  response_time_topk_table u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow copy of the table and the running totals
  logic        tbl_live  [TABLE_ENTRIES];
  logic [31:0] tbl_addr  [TABLE_ENTRIES];
  logic [30:0] tbl_resp  [TABLE_ENTRIES];
  logic [31:0] tbl_stamp [TABLE_ENTRIES];
  logic [63:0] ivl_sum;
  logic [63:0] ivl_count;

  // shadow copy of the registers
  logic        reg_enable;
  logic [6:0]  reg_entries;
  logic [12:0] reg_period;
  logic [9:0]  reg_tps;

  // stimulus and scoreboard state
  in_item_t    pending_requests[$];
  out_item_t   expected_results[$];
  int          mismatches = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  bit          req_taken = 1'b0;
  logic [31:0] clock_now;
  logic [31:0] addr_pool[$];

  // wrap-safe "a is earlier than b"
  function automatic bit tick_earlier(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  function automatic logic [31:0] period_ticks();
    return 32'(reg_period) * 32'(reg_tps);
  endfunction

  // frees stale slots, returns 0 when the limit is negative and the table is skipped
  function automatic bit age_out_stale(logic [31:0] now);
    logic [31:0] lim;
    lim = now - period_ticks();
    if (lim[31]) return 1'b0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (tbl_live[i] && tick_earlier(tbl_stamp[i], lim)) begin
        tbl_live[i] = 1'b0;
        tbl_addr[i] = '0;
        tbl_resp[i] = '0;
        tbl_stamp[i] = '0;
      end
    end
    return 1'b1;
  endfunction

  function automatic out_item_t predict_table_result(in_item_t it);
    out_item_t   r;
    logic [31:0] diff;
    logic [30:0] ivl;
    int          hit;
    int          best;
    int          bound;
    r = '0;
    hit = -1;
    best = -1;
    if (it.action) begin
      void'(age_out_stale(it.now_tick));
      r.status = ST_READ;
      hit = it.read_slot;
    end else if (!reg_enable || it.arrival_tick == 0 || it.retransmitted || !it.ipv4_family) begin
      r.status = ST_IGNORED;
    end else begin
      diff = it.now_tick - it.arrival_tick;
      ivl = diff[31] ? RESP_MAX : diff[30:0];
      ivl_sum += 64'(ivl);
      ivl_count += 64'd1;
      if (!age_out_stale(it.now_tick)) begin
        r.status = ST_SKIPPED;
      end else begin
        // matching address first
        for (int i = 0; i < TABLE_ENTRIES && hit < 0; i++) begin
          if (tbl_live[i] && tbl_addr[i] == it.client_address) hit = i;
        end
        if (hit >= 0) begin
          if (tbl_resp[hit] >= ivl) begin
            r.status = ST_KEPT;
          end else begin
            if (tick_earlier(tbl_stamp[hit], it.now_tick)) tbl_stamp[hit] = it.now_tick;
            tbl_resp[hit] = ivl;
            r.status = ST_RAISED;
          end
        end else begin
          // lowest free slot within the allocation bound
          bound = (reg_entries > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(reg_entries);
          for (int i = 0; i < bound && hit < 0; i++) begin
            if (!tbl_live[i]) hit = i;
          end
          if (hit >= 0) begin
            tbl_live[hit] = 1'b1;
            tbl_addr[hit] = it.client_address;
            tbl_resp[hit] = ivl;
            tbl_stamp[hit] = it.now_tick;
            r.status = ST_INSERTED;
          end else begin
            // smallest live entry, lowest slot on ties
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
              if (tbl_live[i] && (best < 0 || tbl_resp[i] < tbl_resp[best])) best = i;
            end
            if (best < 0 || ivl <= tbl_resp[best]) begin
              r.status = ST_DROPPED;
            end else begin
              if (tick_earlier(tbl_stamp[best], it.now_tick)) tbl_stamp[best] = it.now_tick;
              tbl_resp[best] = ivl;
              tbl_addr[best] = it.client_address;
              hit = best;
              r.status = ST_REPLACED;
            end
          end
        end
      end
    end
    if (hit >= 0) begin
      r.slot = 6'(hit);
      r.entry_valid = tbl_live[hit];
      r.entry_address = tbl_addr[hit];
      r.entry_response = tbl_resp[hit];
      r.entry_stamp = tbl_stamp[hit];
    end
    r.total_sum = ivl_sum;
    r.total_count = ivl_count;
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // monitor: inputs and outputs sampled at the rising edge
  always @(posedge clk) begin
    out_item_t e;
    req_taken = rst_n && in_valid && !in_stall;
    if (req_taken) expected_results.push_back(predict_table_result(in_data));
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with nothing expected");
        mismatches++;
      end else begin
        e = expected_results.pop_front();
        check_field("status", e.status, out_data.status);
        check_field("slot", e.slot, out_data.slot);
        check_field("entry_valid", e.entry_valid, out_data.entry_valid);
        check_field("entry_address", e.entry_address, out_data.entry_address);
        check_field("entry_response", e.entry_response, out_data.entry_response);
        check_field("entry_stamp", e.entry_stamp, out_data.entry_stamp);
        check_field("total_sum", e.total_sum, out_data.total_sum);
        check_field("total_count", e.total_count, out_data.total_count);
      end
    end
  end

  // driver: changes at the falling edge, payload held while stalled
  always @(negedge clk) begin
    if (rst_n && (!in_valid || req_taken)) begin
      if (pending_requests.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_data <= pending_requests.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ENABLE:  reg_enable = val[0];
      CFG_ENTRIES: reg_entries = val[6:0];
      CFG_PERIOD:  reg_period = val[12:0];
      CFG_TPS:     reg_tps = val[9:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait until every transaction has gone through, then let the pipeline settle
  task automatic drain();
    @(posedge clk);
    while (pending_requests.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (2 * TABLE_ENTRIES + 10) @(posedge clk);
  endtask

  task automatic push_record(logic [31:0] now, logic [31:0] arr, logic [31:0] addr,
                             logic retr, logic v4);
    in_item_t it;
    it = '0;
    it.action = 1'b0;
    it.now_tick = now;
    it.arrival_tick = arr;
    it.client_address = addr;
    it.retransmitted = retr;
    it.ipv4_family = v4;
    it.read_slot = 6'($urandom);
    pending_requests.push_back(it);
  endtask

  task automatic push_read(logic [31:0] now, logic [5:0] slot_idx);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
    it.action = 1'b1;
    it.now_tick = now;
    it.read_slot = slot_idx;
    pending_requests.push_back(it);
  endtask

  task automatic fill_pool(int n);
    addr_pool.delete();
    for (int i = 0; i < n; i++) addr_pool.push_back($urandom);
  endtask

  // mostly well-formed records on an advancing clock, with reads, aging jumps and noise
  task automatic random_traffic(int n, int hold_at);
    int          pick;
    logic [31:0] ivl;
    logic [31:0] per;
    logic [31:0] arr;
    per = period_ticks();
    clock_now = per + $urandom_range(32'h7000_0000);
    for (int k = 0; k < n; k++) begin
      if (k == hold_at) drain();
      pick = $urandom_range(99);
      if (pick < 3) clock_now += per + $urandom_range(per);
      else clock_now += $urandom_range(per / 8 + 1);
      if (pick < 10) begin
        push_read(clock_now, 6'($urandom));
      end else if (pick < 20) begin
        // noise: any field value at all
        push_record($urandom, ($urandom_range(3) == 0) ? 32'd0 : $urandom, $urandom,
                    1'($urandom), 1'($urandom));
      end else begin
        ivl = ($urandom_range(19) == 0) ? $urandom : $urandom_range(per / 2 + 50);
        arr = clock_now - ivl;
        if (arr == 0) arr = 32'd1;
        push_record(clock_now, arr, addr_pool[$urandom_range(addr_pool.size() - 1)],
                    1'b0, 1'b1);
      end
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      tbl_live[i] = 1'b0;
      tbl_addr[i] = '0;
      tbl_resp[i] = '0;
      tbl_stamp[i] = '0;
    end
    ivl_sum = '0;
    ivl_count = '0;
    reg_enable = 1'b1;
    reg_entries = 7'd64;
    reg_period = 13'd60;
    reg_tps = 10'd100;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, ignored records, skipped table, raise/keep, reads
    push_read(32'd10000, 6'd0);
    push_read(32'hFFFF_FFFF, 6'd63);
    push_record(32'd10000, 32'd0, 32'h0A00_0001, 1'b0, 1'b1);
    push_record(32'd10000, 32'd9000, 32'h0A00_0001, 1'b1, 1'b1);
    push_record(32'd10000, 32'd9000, 32'h0A00_0001, 1'b0, 1'b0);
    push_record(32'd0, 32'hFFFF_FFFF, 32'h0A00_0001, 1'b0, 1'b1);
    push_record(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 1'b0, 1'b1);
    push_record(32'd10000, 32'd9900, 32'h0000_0000, 1'b0, 1'b1);
    push_record(32'd10000, 32'd9000, 32'hFFFF_FFFF, 1'b0, 1'b1);
    push_record(32'd10010, 32'd9990, 32'hFFFF_FFFF, 1'b0, 1'b1);
    push_record(32'd10020, 32'd5000, 32'hFFFF_FFFF, 1'b0, 1'b1);
    push_record(32'd10030, 32'd20000, 32'h0000_0000, 1'b0, 1'b1);
    push_record(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 1'b0, 1'b1);
    push_read(32'd10040, 6'd0);
    push_read(32'd10040, 6'd1);
    push_read(32'd10040, 6'd2);
    push_record(32'd40000, 32'd39999, 32'h0A00_0002, 1'b0, 1'b1);
    push_read(32'd40000, 6'd0);
    push_read(32'h7FFF_FFFF, 6'd2);
    drain();

    // small table and short period: replacement, dropping, aging
    write_reg(CFG_ENTRIES, 32'd4);
    write_reg(CFG_PERIOD, 32'd1);
    write_reg(CFG_TPS, 32'd1000);
    idle_pct = 84;
    stall_pct = 0;
    fill_pool(12);
    random_traffic(90, -1);

    // full table, longest period; sender holds off halfway until all results are in
    write_reg(CFG_ENTRIES, 32'd64);
    write_reg(CFG_PERIOD, 32'd7200);
    idle_pct = 0;
    stall_pct = 84;
    fill_pool(90);
    random_traffic(90, 45);

    // single slot, one-tick period
    write_reg(CFG_ENTRIES, 32'd1);
    write_reg(CFG_PERIOD, 32'd1);
    write_reg(CFG_TPS, 32'd1);
    idle_pct = 17;
    stall_pct = 17;
    fill_pool(6);
    random_traffic(90, -1);

    // disabled, then back on with the reset timing
    write_reg(CFG_ENABLE, 32'd0);
    write_reg(CFG_ENTRIES, 32'd20);
    write_reg(CFG_PERIOD, 32'd60);
    write_reg(CFG_TPS, 32'd100);
    idle_pct = 0;
    stall_pct = 0;
    fill_pool(30);
    random_traffic(30, -1);
    write_reg(CFG_ENABLE, 32'd1);
    random_traffic(90, -1);

    write_reg(CFG_ENTRIES, 32'd64);
    idle_pct = 17;
    stall_pct = 17;
    fill_pool(70);
    random_traffic(90, -1);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
